// File: sv/hrdp_pkg.sv
package hrdp_pkg;

    // Short-item tags, prefix with the size code masked off.
    localparam logic [7:0] TagMask     = 8'hFC;
    localparam logic [7:0] TagInput    = 8'h80;
    localparam logic [7:0] TagOutput   = 8'h90;
    localparam logic [7:0] TagFeature  = 8'hB0;
    localparam logic [7:0] TagPage     = 8'h04;
    localparam logic [7:0] TagReportId = 8'h84;
    localparam logic [7:0] TagSize     = 8'h74;
    localparam logic [7:0] TagCount    = 8'h94;
    localparam logic [7:0] TagUsage    = 8'h08;
    localparam logic [7:0] TagLogMin   = 8'h14;
    localparam logic [7:0] TagLogMax   = 8'h24;
    localparam logic [7:0] TagUseMin   = 8'h18;
    localparam logic [7:0] TagUseMax   = 8'h28;

    localparam logic [1:0] SizeCodeFour = 2'd3;
    localparam logic [2:0] MaxDataBytes = 3'd4;

    typedef struct packed {
        logic [7:0] desc_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]         field_index;
        logic [7:0]         report_number;
        logic [7:0]         main_flags;
        logic [15:0]        bit_position;
        logic [7:0]         field_bits;
        logic [7:0]         field_elements;
        logic [15:0]        page;
        logic [15:0]        last_usage;
        logic signed [31:0] logical_low;
        logic signed [31:0] logical_high;
        logic [31:0]        usage_low;
        logic [31:0]        usage_high;
    } t_out;

endpackage

// File: sv/hid_report_descriptor_parser_top.sv
// HID report descriptor parser, short items only.
// The input channel carries one descriptor byte per transfer together with a
// flag that marks the final byte of the descriptor. The output channel carries
// one field record for every Input, Output or Feature item that completes.
// Global and local settings (usage page, usage, logical and usage limits,
// report size, count and id) are kept between items; a report id restarts the
// bit offset, and every field record advances it by size times count.
// Latency: a record is offered on the output the cycle after the byte that
// completes its item is taken. Throughput: one byte per cycle unless stalled;
// the whole decode and settings update happens in the cycle the byte is taken,
// with a single 8 by 8 multiply and 17-bit saturating add for the offset.
// The output register separates the two sides: while it holds a record the
// input stays ready as long as the receiver takes that record in the same
// cycle. When the receiver stalls with a record pending, input ready drops
// and the record is held unchanged.
// Reset clears all settings, the offset and the record counter. The final
// byte of a descriptor is decoded as usual and then clears the same state,
// dropping any item it leaves unfinished.
module hid_report_descriptor_parser_top
    import hrdp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic [7:0]  r_prefix, n_prefix;
    logic [2:0]  r_bytes_left, n_bytes_left;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_byte_count, n_byte_count;
    logic [15:0] r_page, n_page;
    logic [15:0] r_usage, n_usage;
    logic [31:0] r_log_min, n_log_min;
    logic [31:0] r_log_max, n_log_max;
    logic [31:0] r_use_min, n_use_min;
    logic [31:0] r_use_max, n_use_max;
    logic [7:0]  r_size, n_size;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_report, n_report;
    logic [15:0] r_offset, n_offset;
    logic [7:0]  r_records, n_records;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    logic        in_fire;
    logic        finish;
    logic [7:0]  tag;
    logic [31:0] value;
    logic [31:0] value_ext;
    logic [15:0] span;
    logic [16:0] next_offset;
    logic        emit;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_prefix     = r_prefix;
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_byte_count = r_byte_count;
        finish       = 1'b0;
        if (r_bytes_left == 3'd0) begin
            n_prefix     = i_in_data.desc_byte;
            n_acc        = '0;
            n_byte_count = '0;
            n_bytes_left = (i_in_data.desc_byte[1:0] == SizeCodeFour) ? MaxDataBytes
                         : {1'b0, i_in_data.desc_byte[1:0]};
            finish       = (i_in_data.desc_byte[1:0] == 2'd0);
        end else begin
            n_acc        = r_acc | ({24'd0, i_in_data.desc_byte} << {r_byte_count[1:0], 3'b000});
            n_byte_count = r_byte_count + 3'd1;
            n_bytes_left = r_bytes_left - 3'd1;
            finish       = (r_bytes_left == 3'd1);
        end
    end

    assign tag   = n_prefix & TagMask;
    assign value = n_acc;

    // Logical limits are sign extended from one or two data bytes.
    always_comb begin
        case (n_byte_count)
            3'd0:    value_ext = '0;
            3'd1:    value_ext = {{24{value[7]}}, value[7:0]};
            3'd2:    value_ext = {{16{value[15]}}, value[15:0]};
            default: value_ext = value;
        endcase
    end

    assign span        = {8'd0, r_size} * {8'd0, r_count};
    assign next_offset = {1'b0, r_offset} + {1'b0, span};

    always_comb begin
        n_page      = r_page;
        n_usage     = r_usage;
        n_log_min   = r_log_min;
        n_log_max   = r_log_max;
        n_use_min   = r_use_min;
        n_use_max   = r_use_max;
        n_size      = r_size;
        n_count     = r_count;
        n_report    = r_report;
        n_offset    = r_offset;
        n_records   = r_records;
        emit        = 1'b0;
        if (in_fire && finish) begin
            case (tag)
                TagPage:     n_page    = value[15:0];
                TagUsage:    n_usage   = value[15:0];
                TagLogMin:   n_log_min = value_ext;
                TagLogMax:   n_log_max = value_ext;
                TagUseMin:   n_use_min = value;
                TagUseMax:   n_use_max = value;
                TagSize:     n_size    = value[7:0];
                TagCount:    n_count   = value[7:0];
                TagReportId: begin
                    n_report = value[7:0];
                    n_offset = '0;
                end
                TagInput, TagOutput, TagFeature: begin
                    emit      = 1'b1;
                    n_offset  = next_offset[16] ? 16'hFFFF : next_offset[15:0];
                    n_records = (r_records == 8'hFF) ? r_records : r_records + 8'd1;
                end
                default: emit = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_out                = r_out;
        n_out_valid          = r_out_valid && !i_out_ready;
        if (emit) begin
            n_out_valid          = 1'b1;
            n_out.field_index    = r_records;
            n_out.report_number  = r_report;
            n_out.main_flags     = value[7:0];
            n_out.bit_position   = r_offset;
            n_out.field_bits     = r_size;
            n_out.field_elements = r_count;
            n_out.page           = r_page;
            n_out.last_usage     = r_usage;
            n_out.logical_low    = r_log_min;
            n_out.logical_high   = r_log_max;
            n_out.usage_low      = r_use_min;
            n_out.usage_high     = r_use_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix     <= '0;
            r_bytes_left <= '0;
            r_acc        <= '0;
            r_byte_count <= '0;
            r_page       <= '0;
            r_usage      <= '0;
            r_log_min    <= '0;
            r_log_max    <= '0;
            r_use_min    <= '0;
            r_use_max    <= '0;
            r_size       <= '0;
            r_count      <= '0;
            r_report     <= '0;
            r_offset     <= '0;
            r_records    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_fire && i_in_data.last_byte) begin
                r_prefix     <= '0;
                r_bytes_left <= '0;
                r_acc        <= '0;
                r_byte_count <= '0;
                r_page       <= '0;
                r_usage      <= '0;
                r_log_min    <= '0;
                r_log_max    <= '0;
                r_use_min    <= '0;
                r_use_max    <= '0;
                r_size       <= '0;
                r_count      <= '0;
                r_report     <= '0;
                r_offset     <= '0;
                r_records    <= '0;
            end else if (in_fire) begin
                r_prefix     <= n_prefix;
                r_bytes_left <= n_bytes_left;
                r_acc        <= n_acc;
                r_byte_count <= n_byte_count;
                r_page       <= n_page;
                r_usage      <= n_usage;
                r_log_min    <= n_log_min;
                r_log_max    <= n_log_max;
                r_use_min    <= n_use_min;
                r_use_max    <= n_use_max;
                r_size       <= n_size;
                r_count      <= n_count;
                r_report     <= n_report;
                r_offset     <= n_offset;
                r_records    <= n_records;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef ASSERT_OFF
    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_byte_count} + {1'b0, r_bytes_left}) <= {1'b0, MaxDataBytes})
        else $error("data byte counters exceed four bytes per item");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.last_byte) |=>
            (r_bytes_left == 3'd0 && r_offset == 16'd0 && r_records == 8'd0))
        else $error("parser state not cleared after final descriptor byte");

    a_records_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in_data.last_byte) |=> (r_records >= $past(r_records)))
        else $error("record counter decreased within a descriptor");

    a_no_spurious_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_fire && !o_out_valid) |=> !o_out_valid)
        else $error("record offered without an accepted byte");
`endif

endmodule
